// File: sv/spfsal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Transaction types, operation and status codes shared by the allocator.
// ----------------------------------------------------------------------------
package spfsal_pkg;

  // Widths of the transaction fields.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned COUNT_W = 11;

  // Width used for range compares against the pool size (covers 65536).
  localparam int unsigned WIDE_W = 17;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

  // Request transaction.
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] slot_id;
    logic [SLOT_W-1:0] active_index;
  } req_t;

  // Result transaction.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  result_slot;
    logic [SLOT_W-1:0]  result_position;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] active_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear_step;
    logic decide;
    logic fix;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic need_fix;
  } dp_stat_t;

endpackage

// File: sv/spfsal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot pool allocator controller
// Sequences the post-reset clearing sweep and the steps of each operation.
// ----------------------------------------------------------------------------
module spfsal_ctrl
  import spfsal_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  // State codes.
  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_FIX    = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = stat_i.need_fix ? S_FIX : S_IDLE;
      end
      S_FIX: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register; the block starts by sweeping the slot table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o.accept     = (state_q == S_IDLE) && start;
    cmd_o.clear_step = (state_q == S_CLEAR);
    cmd_o.decide     = (state_q == S_DECIDE);
    cmd_o.fix        = (state_q == S_FIX);
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: sv/spfsal_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot pool allocator datapath
// Free stack, active list and slot table memories with the count registers.
// ----------------------------------------------------------------------------
module spfsal_dp
  import spfsal_pkg::*;
#(
  parameter int unsigned SLOTS = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o,
  input  req_t      req_i,
  output logic      done_o,
  output rsp_t      rsp_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned SE_W  = IDX_W + 1;

  localparam logic [CNT_W-1:0]  SLOTS_C    = CNT_W'(SLOTS);
  localparam logic [WIDE_W-1:0] SLOTS_WIDE = WIDE_W'(SLOTS);
  localparam logic [IDX_W-1:0]  LAST_ADDR  = IDX_W'(SLOTS - 1);

  // Memories. A slot table entry holds the live flag over the active position.
  logic [IDX_W-1:0] fs_mem [SLOTS];
  logic [IDX_W-1:0] al_mem [SLOTS];
  logic [SE_W-1:0]  si_mem [SLOTS];

  logic [IDX_W-1:0] fs_rd_q, al_rd_q;
  logic [SE_W-1:0]  si_rd_q;

  req_t             req_q;
  logic [CNT_W-1:0] top_q, top_d, live_q, live_d, wm_q, wm_d;
  logic [IDX_W-1:0] clr_cnt_q;
  logic [IDX_W-1:0] fix_slot_q, fix_pos_q;
  rsp_t             rsp_q, rsp_d;
  logic             done_q, done_d;

  // Read address generation from the incoming transaction.
  logic [CNT_W-1:0]  pop_idx, last_idx;
  logic [WIDE_W-1:0] in_sid_wide, in_idx_wide;
  logic [IDX_W-1:0]  fs_raddr, al_raddr, si_raddr;

  assign pop_idx     = top_q - CNT_W'(1);
  assign last_idx    = live_q - CNT_W'(1);
  assign in_sid_wide = WIDE_W'(req_i.slot_id);
  assign in_idx_wide = WIDE_W'(req_i.active_index);
  assign fs_raddr    = pop_idx[IDX_W-1:0];
  assign si_raddr    = in_sid_wide[IDX_W-1:0];
  assign al_raddr    = (req_i.operation == OP_RELEASE) ? last_idx[IDX_W-1:0]
                                                       : in_idx_wide[IDX_W-1:0];

  // Registered memory reads and request capture at acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q   <= req_i;
      fs_rd_q <= fs_mem[fs_raddr];
      al_rd_q <= al_mem[al_raddr];
      si_rd_q <= si_mem[si_raddr];
    end
  end

  // Decisions on the captured request and the read data.
  logic [WIDE_W-1:0] sid_wide, idx_wide, live_wide;
  logic              alloc_ok, pop_fresh, rel_ok, rd_ok, need_fix;
  logic [IDX_W-1:0]  alloc_slot, rel_pos;

  assign sid_wide   = WIDE_W'(req_q.slot_id);
  assign idx_wide   = WIDE_W'(req_q.active_index);
  assign live_wide  = WIDE_W'(live_q);
  // Stack entries below the low-water mark were never written: entry i stands for slot i.
  assign pop_fresh  = (pop_idx < wm_q);
  assign alloc_slot = pop_fresh ? pop_idx[IDX_W-1:0] : fs_rd_q;
  assign alloc_ok   = cmd_i.decide && (req_q.operation == OP_ALLOC) && (top_q != '0);
  assign rel_ok     = cmd_i.decide && (req_q.operation == OP_RELEASE) &&
                      (sid_wide < SLOTS_WIDE) && si_rd_q[IDX_W];
  assign rel_pos    = si_rd_q[IDX_W-1:0];
  assign need_fix   = rel_ok && (CNT_W'(rel_pos) < last_idx);
  assign rd_ok      = cmd_i.decide && (req_q.operation == OP_READ) &&
                      (idx_wide < live_wide);

  assign stat_o.need_fix   = need_fix;
  assign stat_o.clear_last = (clr_cnt_q == LAST_ADDR);

  // Slot table write port: clearing sweep, allocate, release, then mover fix.
  logic             si_we;
  logic [IDX_W-1:0] si_waddr;
  logic [SE_W-1:0]  si_wdata;

  always_comb begin
    si_we    = 1'b0;
    si_waddr = clr_cnt_q;
    si_wdata = '0;
    if (cmd_i.clear_step) begin
      si_we = 1'b1;
    end else if (alloc_ok) begin
      si_we    = 1'b1;
      si_waddr = alloc_slot;
      si_wdata = {1'b1, live_q[IDX_W-1:0]};
    end else if (rel_ok) begin
      si_we    = 1'b1;
      si_waddr = sid_wide[IDX_W-1:0];
    end else if (cmd_i.fix) begin
      si_we    = 1'b1;
      si_waddr = fix_slot_q;
      si_wdata = {1'b1, fix_pos_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (si_we) begin
      si_mem[si_waddr] <= si_wdata;
    end
  end

  // Active list write port: append on allocate, fill the hole on release.
  logic             al_we;
  logic [IDX_W-1:0] al_waddr, al_wdata;

  always_comb begin
    al_we    = 1'b0;
    al_waddr = live_q[IDX_W-1:0];
    al_wdata = alloc_slot;
    if (alloc_ok) begin
      al_we = 1'b1;
    end else if (need_fix) begin
      al_we    = 1'b1;
      al_waddr = rel_pos;
      al_wdata = al_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (al_we) begin
      al_mem[al_waddr] <= al_wdata;
    end
  end

  // Free stack write port: push on release.
  always_ff @(posedge clk_i) begin
    if (rel_ok) begin
      fs_mem[top_q[IDX_W-1:0]] <= sid_wide[IDX_W-1:0];
    end
  end

  // Mover bookkeeping for the second table write of a release.
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      fix_slot_q <= al_rd_q;
      fix_pos_q  <= rel_pos;
    end
  end

  // Count and low-water mark updates.
  always_comb begin
    top_d  = top_q;
    live_d = live_q;
    wm_d   = wm_q;
    if (alloc_ok) begin
      top_d  = pop_idx;
      live_d = live_q + CNT_W'(1);
      if (pop_fresh) begin
        wm_d = pop_idx;
      end
    end else if (rel_ok) begin
      top_d  = top_q + CNT_W'(1);
      live_d = last_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q     <= SLOTS_C;
      live_q    <= '0;
      wm_q      <= SLOTS_C;
      clr_cnt_q <= '0;
    end else begin
      top_q  <= top_d;
      live_q <= live_d;
      wm_q   <= wm_d;
      if (cmd_i.clear_step) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      end
    end
  end

  // Result transaction assembly.
  always_comb begin
    rsp_d = rsp_q;
    if (cmd_i.decide) begin
      rsp_d.status          = ST_BAD;
      rsp_d.result_slot     = '0;
      rsp_d.result_position = '0;
      if ((req_q.operation == OP_ALLOC) && (top_q == '0)) begin
        rsp_d.status = ST_EMPTY;
      end else if (alloc_ok) begin
        rsp_d.status          = ST_OK;
        rsp_d.result_slot     = SLOT_W'(WIDE_W'(alloc_slot));
        rsp_d.result_position = SLOT_W'(live_wide);
      end else if (rel_ok) begin
        rsp_d.status = ST_OK;
      end else if (rd_ok) begin
        rsp_d.status          = ST_OK;
        rsp_d.result_slot     = SLOT_W'(WIDE_W'(al_rd_q));
        rsp_d.result_position = req_q.active_index;
      end
      rsp_d.free_count   = COUNT_W'(WIDE_W'(top_d));
      rsp_d.active_count = COUNT_W'(WIDE_W'(live_d));
    end
  end

  assign done_d = (cmd_i.decide && !need_fix) || cmd_i.fix;

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: sv/slot_pool_free_stack_active_list_unit.sv
`timescale 1ns / 1ps
// Allocate, read and failed operations pass through the acceptance step and a decide step.
// A release that moves the last active entry adds a fix step, the second write
// through the single write port of the slot table. done_o strobes in the cycle after the
// last step, and start is taken again in that same cycle. After reset, busy stays high
// while the slot table is swept clear, one entry per cycle.
// ----------------------------------------------------------------------------
// Slot pool allocator with free stack and dense active list
// Pops free slots from a stack, keeps live slots in a dense list, and
// returns released slots to the stack by swapping in the last list entry.
// ----------------------------------------------------------------------------
module slot_pool_free_stack_active_list_unit
  import spfsal_pkg::*;
#(
  parameter int unsigned SLOTS = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer.
  spfsal_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Memories and counters.
  spfsal_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

// File: sv/spfsal_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot pool allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module spfsal_chk
  import spfsal_pkg::*;
#(
  parameter int unsigned SLOTS = 1024
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input rsp_t rsp_o
);

  // An accepted transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // Results never come in consecutive cycles, and each follows a busy cycle.
  a_done_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !$past(done_o)))
    else $error("result strobe without a preceding busy cycle");

  // Free and active counts in every result add up to the pool size.
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (COUNT_W'(rsp_o.free_count + rsp_o.active_count) == COUNT_W'(SLOTS)))
    else $error("free and active counts do not add up to the pool size");

  // An empty report means no free slot is left.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == ST_EMPTY)) |-> (rsp_o.free_count == '0))
    else $error("empty status with free slots left");

  // Failed transactions carry zero slot and position.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status != ST_OK)) |->
      ((rsp_o.result_slot == '0) && (rsp_o.result_position == '0)))
    else $error("failed transaction carries a slot or position");

endmodule

bind slot_pool_free_stack_active_list_unit spfsal_chk #(
  .SLOTS (SLOTS)
) u_spfsal_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// File: test/slot_pool_free_stack_active_list_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot pool allocator testbench
// Drives allocate, release and read commands through the start/busy handshake
// and checks every done strobe against a cycle-free model of the free stack,
// the dense active list and the per-slot position table.
// ----------------------------------------------------------------------------
module slot_pool_free_stack_active_list_unit_tb;
  import spfsal_pkg::*;

  localparam int unsigned POOL_SLOTS = 1024;

  // The package names three operations; the fourth code is rejected.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // One queued command and the idle cycles the sender spends before it.
  typedef struct {
    req_t        req;
    int unsigned gap;
    bit          drain;
  } cmd_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;

  // Sender and receiver bookkeeping.
  cmd_t        cmd_q[$];
  rsp_t        due_rsp_q[$];
  int unsigned issue_cnt = 0;
  int unsigned accept_cnt = 0;
  int          gap_left = -1;
  bit          no_gap = 1'b0;
  int unsigned err_cnt = 0;

  // Shadow copy of the allocator state.
  logic [SLOT_W-1:0] free_stk[POOL_SLOTS];
  logic [SLOT_W-1:0] act_list[POOL_SLOTS];
  logic [SLOT_W-1:0] pos_of[POOL_SLOTS];
  bit                live[POOL_SLOTS];
  int unsigned       free_top;
  int unsigned       live_n;

  slot_pool_free_stack_active_list_unit #(
    .SLOTS(POOL_SLOTS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Apply one command to the shadow state and return the response it must produce.
  function automatic rsp_t pool_apply(req_t r);
    rsp_t              y;
    logic [SLOT_W-1:0] s;
    int unsigned       pos;
    y = '0;
    y.status = ST_BAD;
    case (r.operation)
      OP_ALLOC: begin
        if (free_top == 0 || live_n >= POOL_SLOTS) begin
          y.status = ST_EMPTY;
        end else begin
          free_top--;
          s = free_stk[free_top];
          act_list[live_n] = s;
          pos_of[s] = SLOT_W'(live_n);
          live[s] = 1'b1;
          y.result_slot = s;
          y.result_position = SLOT_W'(live_n);
          live_n++;
          y.status = ST_OK;
        end
      end
      OP_RELEASE: begin
        if (live[r.slot_id] && live_n > 0 && free_top < POOL_SLOTS) begin
          pos = 32'(pos_of[r.slot_id]);
          // The last active entry fills the hole unless the hole is the last entry.
          if (pos < live_n - 1) begin
            s = act_list[live_n - 1];
            act_list[pos] = s;
            pos_of[s] = SLOT_W'(pos);
          end
          live_n--;
          live[r.slot_id] = 1'b0;
          free_stk[free_top] = r.slot_id;
          free_top++;
          y.status = ST_OK;
        end
      end
      OP_READ: begin
        if (r.active_index < live_n) begin
          y.result_slot = act_list[r.active_index];
          y.result_position = r.active_index;
          y.status = ST_OK;
        end
      end
      default: begin
        y.status = ST_BAD;
      end
    endcase
    y.free_count = COUNT_W'(free_top);
    y.active_count = COUNT_W'(live_n);
    return y;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [COUNT_W-1:0] got, logic [COUNT_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    end
  endtask

  function automatic req_t rand_req();
    req_t        r;
    logic [31:0] w;
    w = $urandom;
    r = w[$bits(req_t)-1:0];
    return r;
  endfunction

  task automatic queue_cmd(req_t r, bit drain);
    cmd_t c;
    c.req = r;
    c.gap = no_gap ? 0 : $urandom_range(0, 6);
    c.drain = drain;
    cmd_q.insert(cmd_q.size(), c);
  endtask

  // Wait until every queued command is accepted and every response has arrived.
  task automatic wait_quiet();
    while (cmd_q.size() != 0 || accept_cnt != issue_cnt || due_rsp_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Random mix; releases mostly target live slots, and reads on odd picks target live positions.
  task automatic push_mix(int unsigned n, int unsigned p_alloc, int unsigned p_rel);
    req_t        r;
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      while (cmd_q.size() >= 2) @(posedge clk_i);
      if (k % 40 == 0) no_gap = ($urandom_range(0, 2) == 0);
      r = rand_req();
      pick = $urandom_range(0, 99);
      if (pick < p_alloc) begin
        r.operation = OP_ALLOC;
      end else if (pick < p_alloc + p_rel) begin
        r.operation = OP_RELEASE;
        if (live_n != 0) r.slot_id = act_list[$urandom_range(0, live_n - 1)];
      end else if (pick < p_alloc + p_rel + 5) begin
        r.operation = OP_RELEASE;
      end else if (pick < 95) begin
        r.operation = OP_READ;
        if (live_n != 0 && pick[0]) r.active_index = SLOT_W'($urandom_range(0, live_n - 1));
      end else begin
        r.operation = OP_SPARE;
      end
      queue_cmd(r, 1'b0);
    end
  endtask

  // Driver: issues the next command at the falling edge once the previous one is taken.
  always @(negedge clk_i) begin
    logic nxt;
    cmd_t c;
    nxt = start;
    if (rst_ni && !(start && accept_cnt != issue_cnt)) begin
      nxt = 1'b0;
      if (cmd_q.size() != 0) begin
        if (gap_left < 0) gap_left = cmd_q[0].gap;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(cmd_q[0].drain && due_rsp_q.size() != 0)) begin
          c = cmd_q.pop_front();
          req_i <= c.req;
          nxt = 1'b1;
          issue_cnt++;
          gap_left = -1;
        end
      end
    end
    start <= nxt;
  end

  // Monitor: checks each result, then records an accepted transaction.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (due_rsp_q.size() == 0) begin
          report_mismatch("result strobe with no transaction outstanding");
        end else begin
          want = due_rsp_q.pop_front();
          check_field("status", COUNT_W'(rsp_o.status), COUNT_W'(want.status));
          check_field("result_slot", COUNT_W'(rsp_o.result_slot),
                      COUNT_W'(want.result_slot));
          check_field("result_position", COUNT_W'(rsp_o.result_position),
                      COUNT_W'(want.result_position));
          check_field("free_count", rsp_o.free_count, want.free_count);
          check_field("active_count", rsp_o.active_count, want.active_count);
        end
      end
      if (start && !busy) begin
        due_rsp_q.insert(due_rsp_q.size(), pool_apply(req_i));
        accept_cnt++;
      end
    end
  end

  // Stimulus and end of test.
  initial begin
    req_t        r;
    int unsigned n;
    for (int unsigned i = 0; i < POOL_SLOTS; i++) begin
      free_stk[i] = SLOT_W'(i);
      act_list[i] = '0;
      pos_of[i] = '0;
      live[i] = 1'b0;
    end
    free_top = POOL_SLOTS;
    live_n = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list reads, releases of dead slots, the spare code,
    // swap-in on release, release of the last entry, double release, reuse.
    r = rand_req(); r.operation = OP_READ; r.active_index = '0; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_RELEASE; r.slot_id = '0; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_RELEASE; r.slot_id = '1; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_SPARE; queue_cmd(r, 1'b0);
    repeat (4) begin
      r = rand_req(); r.operation = OP_ALLOC; queue_cmd(r, 1'b0);
    end
    r = rand_req(); r.operation = OP_READ; r.active_index = 10'd0; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_READ; r.active_index = 10'd3; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_READ; r.active_index = 10'd4; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_READ; r.active_index = '1; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_RELEASE; r.slot_id = 10'd1022; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_READ; r.active_index = 10'd1; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_RELEASE; r.slot_id = 10'd1021; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_RELEASE; r.slot_id = 10'd1021; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_ALLOC; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_RELEASE; r.slot_id = 10'd1023; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_READ; r.active_index = 10'd0; queue_cmd(r, 1'b0);
    r = '1; r.operation = OP_SPARE; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_RELEASE; r.slot_id = 10'd1023; queue_cmd(r, 1'b0);

    push_mix(300, 45, 30);
    wait_quiet();

    // Fill the pool completely, then run into the empty-pool case.
    n = POOL_SLOTS - live_n;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 64 == 0) no_gap = ($urandom_range(0, 1) == 0);
      r = rand_req(); r.operation = OP_ALLOC; queue_cmd(r, k == 0);
      if ($urandom_range(0, 7) == 0) begin
        r = rand_req(); r.operation = OP_READ; queue_cmd(r, 1'b0);
      end
    end
    no_gap = 1'b0;
    repeat (3) begin
      r = rand_req(); r.operation = OP_ALLOC; queue_cmd(r, 1'b0);
    end
    r = rand_req(); r.operation = OP_READ; r.active_index = '1; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_RELEASE; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_ALLOC; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_ALLOC; queue_cmd(r, 1'b0);
    r = rand_req(); r.operation = OP_READ; r.active_index = '1; queue_cmd(r, 1'b0);
    wait_quiet();

    // Release-heavy stretch from a full pool, then a balanced tail.
    push_mix(350, 10, 60);
    push_mix(50, 45, 30);

    wait_quiet();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("** slot_pool_free_stack_active_list_unit: PASSED **");
    end else begin
      $display("** slot_pool_free_stack_active_list_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #1000000;
    $display("** slot_pool_free_stack_active_list_unit: FAILED **");
    $finish;
  end

endmodule
